>>> rtl/window_mode_color_filter_unit_defines.svh
// Assertion macros shared by the window mode colour filter RTL.
`ifndef WINDOW_MODE_COLOR_FILTER_UNIT_DEFINES_SVH
`define WINDOW_MODE_COLOR_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define WMCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmcf assertion failed");

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define WMCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmcf assertion failed");

`endif

>>> rtl/wmcf_pkg.sv
// Package: sizes, codes and shared types of the window mode colour filter.
`default_nettype none
package wmcf_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 256;
  localparam int COLOR_SLOTS = 4;

  localparam int ROW_W = 8;
  localparam int COL_W = 8;
  localparam int CH_W  = 8;
  localparam int RGB_W = 3 * CH_W;
  localparam int CNT_W = 8;
  localparam int DIM_W = 9;
  localparam int RAD_W = 3;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [RGB_W-1:0] WHITE_RGB    = {RGB_W{1'b1}};
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE = {CH_W{1'b1}};

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam int CFG_DATA_W = DIM_W;

  // control from the scan sequencer to the slot bank
  typedef struct packed {
    logic clear;
    logic upd;
  } slot_ctl_t;

endpackage
`default_nettype wire

>>> rtl/wmcf_in_if.sv
// Interface: input item channel (pixel writes and queries).
`default_nettype none
interface wmcf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [wmcf_pkg::ROW_W-1:0]   row;
  logic [wmcf_pkg::COL_W-1:0]   col;
  logic [wmcf_pkg::CH_W-1:0]    in_red;
  logic [wmcf_pkg::CH_W-1:0]    in_green;
  logic [wmcf_pkg::CH_W-1:0]    in_blue;

  modport source (output valid, action, row, col, in_red, in_green, in_blue,
                  input ready);
  modport sink   (input valid, action, row, col, in_red, in_green, in_blue,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/wmcf_out_if.sv
// Interface: result channel (filtered pixel).
`default_nettype none
interface wmcf_out_if;
  logic                      valid;
  logic                      ready;
  logic [wmcf_pkg::CH_W-1:0] out_red;
  logic [wmcf_pkg::CH_W-1:0] out_green;
  logic [wmcf_pkg::CH_W-1:0] out_blue;
  logic [wmcf_pkg::CH_W-1:0] out_alpha;
  logic                      bad_position;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, bad_position,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, bad_position,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/wmcf_cfg_if.sv
// Interface: configuration register write channel.
`default_nettype none
interface wmcf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [wmcf_pkg::REG_IDX_W-1:0]     reg_index;
  logic [wmcf_pkg::CFG_DATA_W-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

>>> rtl/wmcf_slot_bank.sv
// Colour slot bank: counts window colours and picks the most frequent one.
`default_nettype none
module wmcf_slot_bank (
  input  wire logic                            clk,
  input  wire wmcf_pkg::slot_ctl_t             ctl,
  input  wire logic [wmcf_pkg::RGB_W-1:0]      px,
  output logic      [wmcf_pkg::RGB_W-1:0]      win_rgb
);

  logic [wmcf_pkg::RGB_W-1:0] slot_rgb_r   [wmcf_pkg::COLOR_SLOTS];
  logic [wmcf_pkg::CNT_W-1:0] slot_cnt_r   [wmcf_pkg::COLOR_SLOTS];
  logic [wmcf_pkg::RGB_W-1:0] slot_rgb_nxt [wmcf_pkg::COLOR_SLOTS];
  logic [wmcf_pkg::CNT_W-1:0] slot_cnt_nxt [wmcf_pkg::COLOR_SLOTS];

  // first slot that is empty (white) or already holds the colour takes it
  always_comb begin
    logic taken;
    taken = 1'b0;
    for (int k = 0; k < wmcf_pkg::COLOR_SLOTS; k++) begin
      slot_rgb_nxt[k] = slot_rgb_r[k];
      slot_cnt_nxt[k] = slot_cnt_r[k];
      if (ctl.clear) begin
        slot_rgb_nxt[k] = wmcf_pkg::WHITE_RGB;
        slot_cnt_nxt[k] = '0;
      end else if (ctl.upd && !taken) begin
        if (slot_rgb_r[k] == wmcf_pkg::WHITE_RGB) begin
          slot_rgb_nxt[k] = px;
          slot_cnt_nxt[k] = wmcf_pkg::CNT_W'(1);
          taken           = 1'b1;
        end else if (slot_rgb_r[k] == px) begin
          slot_cnt_nxt[k] = slot_cnt_r[k] + wmcf_pkg::CNT_W'(1);
          taken           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < wmcf_pkg::COLOR_SLOTS; k++) begin
      slot_rgb_r[k] <= slot_rgb_nxt[k];
      slot_cnt_r[k] <= slot_cnt_nxt[k];
    end
  end

  // highest count wins, earliest slot on a tie
  always_comb begin
    logic [wmcf_pkg::CNT_W-1:0] best_cnt;
    best_cnt = slot_cnt_r[0];
    win_rgb  = slot_rgb_r[0];
    for (int k = 1; k < wmcf_pkg::COLOR_SLOTS; k++) begin
      if (slot_cnt_r[k] > best_cnt) begin
        best_cnt = slot_cnt_r[k];
        win_rgb  = slot_rgb_r[k];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/window_mode_color_filter_unit.sv
// Top level: frame store, window scan sequencer and result register.
// Write: stored at the accepting edge if inside the frame; the next may follow at once; no result.
// Query in the frame: SCAN reads the clipped window, one store read a cycle, then
//   DRAIN and FIN; FIN registers the result once the result register is free.
// Query off the frame: straight to FIN; result is zero colour with bad_position set.
// Reset (rst_n low, synchronous): control cleared, frame 256x256, radius 1; store kept.
`default_nettype none
`include "window_mode_color_filter_unit_defines.svh"
module window_mode_color_filter_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  wmcf_in_if.sink   in_ch,
  wmcf_out_if.source out_ch,
  wmcf_cfg_if.sink  cfg_ch
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // takes transactions
  localparam logic [1:0] ST_SCAN  = 2'd1;  // one frame store read per cycle
  localparam logic [1:0] ST_DRAIN = 2'd2;  // last read data lands in the slots
  localparam logic [1:0] ST_FIN   = 2'd3;  // wait for the result register

  // ---------------------------------------------------------------------------
  // Configuration registers; writes always taken
  // ---------------------------------------------------------------------------
  logic [wmcf_pkg::DIM_W-1:0] frame_height_r;
  logic [wmcf_pkg::DIM_W-1:0] frame_width_r;
  logic [wmcf_pkg::RAD_W-1:0] window_radius_r;
  logic                       cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r  <= wmcf_pkg::DIM_W'(256);
      frame_width_r   <= wmcf_pkg::DIM_W'(256);
      window_radius_r <= wmcf_pkg::RAD_W'(1);
    end else if (cfg_fire) begin
      case (cfg_ch.reg_index)
        wmcf_pkg::REG_FRAME_HEIGHT:  frame_height_r  <= cfg_ch.wr_data;
        wmcf_pkg::REG_FRAME_WIDTH:   frame_width_r   <= cfg_ch.wr_data;
        wmcf_pkg::REG_WINDOW_RADIUS: window_radius_r <= cfg_ch.wr_data[wmcf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Oversized frames clip to the store size
  logic [wmcf_pkg::DIM_W-1:0] h_eff;
  logic [wmcf_pkg::DIM_W-1:0] w_eff;
  assign h_eff = (frame_height_r > wmcf_pkg::DIM_W'(wmcf_pkg::MAX_ROWS)) ?
                 wmcf_pkg::DIM_W'(wmcf_pkg::MAX_ROWS) : frame_height_r;
  assign w_eff = (frame_width_r > wmcf_pkg::DIM_W'(wmcf_pkg::MAX_COLS)) ?
                 wmcf_pkg::DIM_W'(wmcf_pkg::MAX_COLS) : frame_width_r;

  // ---------------------------------------------------------------------------
  // Input transaction decode
  // ---------------------------------------------------------------------------
  logic [1:0] state_r, state_nxt;
  logic       in_fire;
  logic       in_frame;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_frame    = ({1'b0, in_ch.row} < h_eff) && ({1'b0, in_ch.col} < w_eff);

  // Window bounds, clipped at the frame edges (inclusive ends)
  logic [wmcf_pkg::DIM_W-1:0] row_far, col_far;
  logic [wmcf_pkg::DIM_W-1:0] h_last, w_last;
  logic [wmcf_pkg::ROW_W-1:0] y_start, y_end;
  logic [wmcf_pkg::COL_W-1:0] x_start, x_end;

  always_comb begin
    row_far = {1'b0, in_ch.row} + wmcf_pkg::DIM_W'(window_radius_r);
    col_far = {1'b0, in_ch.col} + wmcf_pkg::DIM_W'(window_radius_r);
    h_last  = h_eff - wmcf_pkg::DIM_W'(1);
    w_last  = w_eff - wmcf_pkg::DIM_W'(1);
    y_start = (in_ch.row >= wmcf_pkg::ROW_W'(window_radius_r)) ?
              in_ch.row - wmcf_pkg::ROW_W'(window_radius_r) : '0;
    x_start = (in_ch.col >= wmcf_pkg::COL_W'(window_radius_r)) ?
              in_ch.col - wmcf_pkg::COL_W'(window_radius_r) : '0;
    y_end   = (row_far > h_last) ? h_last[wmcf_pkg::ROW_W-1:0] : row_far[wmcf_pkg::ROW_W-1:0];
    x_end   = (col_far > w_last) ? w_last[wmcf_pkg::COL_W-1:0] : col_far[wmcf_pkg::COL_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Scan position
  // ---------------------------------------------------------------------------
  logic [wmcf_pkg::ROW_W-1:0] y_r, y_end_r;
  logic [wmcf_pkg::COL_W-1:0] x_r, x_start_r, x_end_r;
  logic                       bad_r;
  logic                       scan_last;

  assign scan_last = (x_r == x_end_r) && (y_r == y_end_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      y_r       <= y_start;
      y_end_r   <= y_end;
      x_r       <= x_start;
      x_start_r <= x_start;
      x_end_r   <= x_end;
      bad_r     <= !in_frame;
    end else if (state_r == ST_SCAN) begin
      if (x_r == x_end_r) begin
        x_r <= x_start_r;
        y_r <= y_r + wmcf_pkg::ROW_W'(1);
      end else begin
        x_r <= x_r + wmcf_pkg::COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store: one write or one read per cycle, read data registered
  // ---------------------------------------------------------------------------
  logic [wmcf_pkg::RGB_W-1:0]  frame_mem [wmcf_pkg::DEPTH];
  logic [wmcf_pkg::RGB_W-1:0]  rd_data_r;
  logic                        rd_vld_r;
  logic                        mem_we;
  logic [wmcf_pkg::ADDR_W-1:0] wr_addr, rd_addr;

  assign mem_we  = in_fire && (in_ch.action == wmcf_pkg::ACT_WRITE) && in_frame;
  assign wr_addr = wmcf_pkg::ADDR_W'(in_ch.row) * wmcf_pkg::ADDR_W'(wmcf_pkg::MAX_COLS)
                   + wmcf_pkg::ADDR_W'(in_ch.col);
  assign rd_addr = wmcf_pkg::ADDR_W'(y_r) * wmcf_pkg::ADDR_W'(wmcf_pkg::MAX_COLS)
                   + wmcf_pkg::ADDR_W'(x_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    end
    if (state_r == ST_SCAN) begin
      rd_data_r <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
    end
  end

  // ---------------------------------------------------------------------------
  // Colour slots
  // ---------------------------------------------------------------------------
  wmcf_pkg::slot_ctl_t        slot_ctl;
  logic [wmcf_pkg::RGB_W-1:0] win_rgb;

  assign slot_ctl.clear = in_fire && (in_ch.action == wmcf_pkg::ACT_QUERY) && in_frame;
  assign slot_ctl.upd   = rd_vld_r;

  wmcf_slot_bank u_slots (
    .clk     (clk),
    .ctl     (slot_ctl),
    .px      (rd_data_r),
    .win_rgb (win_rgb)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.action == wmcf_pkg::ACT_QUERY)) begin
          state_nxt = in_frame ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: a waiting result does not block the next transaction
  // ---------------------------------------------------------------------------
  logic [wmcf_pkg::RGB_W-1:0] out_rgb_r;
  logic                       out_bad_r;
  logic                       out_load;

  assign out_load = (state_r == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgb_r <= bad_r ? '0 : win_rgb;
      out_bad_r <= bad_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_red      = out_rgb_r[3*wmcf_pkg::CH_W-1:2*wmcf_pkg::CH_W];
  assign out_ch.out_green    = out_rgb_r[2*wmcf_pkg::CH_W-1:wmcf_pkg::CH_W];
  assign out_ch.out_blue     = out_rgb_r[wmcf_pkg::CH_W-1:0];
  assign out_ch.out_alpha    = wmcf_pkg::ALPHA_OPAQUE;
  assign out_ch.bad_position = out_bad_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WMCF_ASSERT_IMP(a_rd_only_scanning, rd_vld_r, (state_r == ST_SCAN) || (state_r == ST_DRAIN))
  `WMCF_ASSERT_NXT(a_query_starts_scan, slot_ctl.clear, state_r == ST_SCAN)
  `WMCF_ASSERT_IMP(a_scan_in_window, state_r == ST_SCAN, (y_r <= y_end_r) && (x_r <= x_end_r))
  `WMCF_ASSERT_NXT(a_fin_loads_result, out_load, out_valid_r && (state_r == ST_IDLE))

endmodule
`default_nettype wire
